// File: sv/bta_pkg.sv
// Shared constants and types for the boundary tag best-fit allocator.
package bta_pkg;

   localparam int HEAP_BYTES_DEF = 65536;
   localparam int INIT_CHUNK     = 1 << 12;
   localparam int CHUNK_RESET    = 4096;
   localparam int CHUNK_W        = 17;
   localparam int BYTES_W        = 16;
   localparam int OFFSET_W       = 17;
   localparam int STATUS_W       = 2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [OFFSET_W-1:0] block_offset;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// File: sv/boundary_tag_best_fit_allocator_top.sv
// Top level of the boundary tag best-fit allocator: CSR, response register, engine.
//
//  channel | ports                                    | handshake
//  req     | req_type, req_request_bytes, req_free_offset | req_valid / req_stall
//  rsp     | rsp_block_offset, rsp_status             | rsp_valid / rsp_stall
//  csr     | csr_chunk_bytes                          | csr_valid / csr_ready
//
// A request walks the heap one block at a time through WALK_RD and WALK_CHK (one
// tag memory read port), then splits, extends and merges blocks as needed.
// After reset every tag memory word is cleared, then 5 init writes follow;
// req_stall stays high meanwhile. A held response does not block the acceptance of
// the next request, only that request's finish.
module boundary_tag_best_fit_allocator_top #(
   parameter int HEAP_BYTES = bta_pkg::HEAP_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [bta_pkg::BYTES_W-1:0]   req_request_bytes,
   input  logic [bta_pkg::OFFSET_W-1:0]  req_free_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bta_pkg::OFFSET_W-1:0]  rsp_block_offset,
   output logic [bta_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bta_pkg::CHUNK_W-1:0]   csr_chunk_bytes
);

   logic [bta_pkg::CHUNK_W-1:0] chunk_ff;
   logic                        rsp_valid_ff;
   bta_pkg::rsp_type            rsp_ff;
   logic                        out_ready;
   logic                        done_valid;
   bta_pkg::rsp_type            done_rsp;

   assign csr_ready        = 1'b1;
   assign out_ready        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_offset = rsp_ff.block_offset;
   assign rsp_status       = rsp_ff.status;

   bta_engine #(.HEAP_BYTES(HEAP_BYTES)) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_type          (req_type),
      .req_request_bytes (req_request_bytes),
      .req_free_offset   (req_free_offset),
      .req_stall         (req_stall),
      .chunk_bytes       (chunk_ff),
      .out_ready         (out_ready),
      .done_valid        (done_valid),
      .done_rsp          (done_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= bta_pkg::CHUNK_W'(bta_pkg::CHUNK_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            chunk_ff <= csr_chunk_bytes;
         end
         if (done_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (done_valid) begin
         rsp_ff <= done_rsp;
      end
   end

endmodule

// File: sv/bta_tag_mem.sv
// Tag memory: one boundary tag per heap word, registered read, range-checked access.
module bta_tag_mem #(
   parameter int HEAP_BYTES = bta_pkg::HEAP_BYTES_DEF,
   parameter int W          = 18,
   parameter int TW         = 17
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [W-1:0]  wr_addr,
   input  logic [TW-1:0] wr_data,
   input  logic [W-1:0]  rd_addr,
   output logic [TW-1:0] rd_data
);

   localparam int TAG_WORDS = HEAP_BYTES / 4;
   localparam int IW        = $clog2(TAG_WORDS);

   logic [TW-1:0] mem_ff [TAG_WORDS];
   logic [TW-1:0] rd_q_ff;
   logic          rd_ok_ff;
   logic          wr_ok;

   assign wr_ok   = wr_addr < W'(HEAP_BYTES);
   assign rd_data = rd_ok_ff ? rd_q_ff : '0;

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem_ff[wr_addr[IW+1:2]] <= wr_data;
      end
      rd_q_ff  <= mem_ff[rd_addr[IW+1:2]];
      rd_ok_ff <= rd_addr < W'(HEAP_BYTES);
   end

endmodule

// File: sv/bta_engine.sv
// Allocator sequencer: heap walk, split, extend and coalesce over the tag memory.
module bta_engine #(
   parameter int HEAP_BYTES = bta_pkg::HEAP_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_type,
   input  logic [bta_pkg::BYTES_W-1:0]  req_request_bytes,
   input  logic [bta_pkg::OFFSET_W-1:0] req_free_offset,
   output logic                         req_stall,
   input  logic [bta_pkg::CHUNK_W-1:0]  chunk_bytes,
   input  logic                         out_ready,
   output logic                         done_valid,
   output bta_pkg::rsp_type             done_rsp
);

   localparam int AW        = $clog2(HEAP_BYTES) + 1;
   localparam int TW        = AW;
   localparam int W         = (AW + 1 > 18) ? AW + 1 : 18;
   localparam int TAG_WORDS = HEAP_BYTES / 4;

   typedef enum logic [4:0] {
      CLEAR, INIT, IDLE, WALK_RD, WALK_CHK, ALLOC_END, EXT_RD, EXT_CHK, EXT_TST,
      EXT_EPI, MRG_A, MRG_B, MRG_C, MRG_D, PLC_RD, PLC_CHK, PLC_SPLIT, SB_HDR,
      SB_FTR, DONE
   } state_type;

   state_type state_ff, state_in, sb_ret_ff, sb_ret_in;
   logic [W-1:0]  cnt_ff, cnt_in;
   logic [2:0]    step_ff, step_in;
   logic          op_free_ff, op_free_in;
   logic [bta_pkg::OFFSET_W-1:0] off_ff, off_in;
   logic [W-1:0]  asize_ff, asize_in, h_ff, h_in, best_ff, best_in, best_sz_ff, best_sz_in;
   logic [W-1:0]  brk_ff, brk_in, epi_ff, epi_in, p_ff, p_in, sz_ff, sz_in, ext_ff, ext_in;
   logic [TW-1:0] prev_ff, prev_in;
   logic [1:0]    guard_ff, guard_in;
   logic [W-1:0]  sb_p_ff, sb_p_in, sb_size_ff, sb_size_in;
   logic          sb_used_ff, sb_used_in;
   logic [bta_pkg::OFFSET_W-1:0] res_off_ff, res_off_in;
   logic [bta_pkg::STATUS_W-1:0] res_st_ff, res_st_in;

   logic          mem_we;
   logic [W-1:0]  mem_waddr, mem_raddr;
   logic [TW-1:0] mem_wdata, rd_data;
   logic [W-1:0]  rd_size, chunk, psz, nsz, msize, mp;

   bta_tag_mem #(.HEAP_BYTES(HEAP_BYTES), .W(W), .TW(TW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   assign rd_size    = W'({rd_data[TW-1:1], 1'b0});
   assign req_stall  = state_ff != IDLE;
   assign done_valid = (state_ff == DONE) && out_ready;
   assign done_rsp   = '{block_offset: res_off_ff, status: res_st_ff};

   always_comb begin
      state_in   = state_ff;
      sb_ret_in  = sb_ret_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      op_free_in = op_free_ff;
      off_in     = off_ff;
      asize_in   = asize_ff;
      h_in       = h_ff;
      best_in    = best_ff;
      best_sz_in = best_sz_ff;
      brk_in     = brk_ff;
      epi_in     = epi_ff;
      p_in       = p_ff;
      sz_in      = sz_ff;
      ext_in     = ext_ff;
      prev_in    = prev_ff;
      guard_in   = guard_ff;
      sb_p_in    = sb_p_ff;
      sb_size_in = sb_size_ff;
      sb_used_in = sb_used_ff;
      res_off_in = res_off_ff;
      res_st_in  = res_st_ff;
      mem_we     = 1'b0;
      mem_waddr  = sb_p_ff - W'(4);
      mem_wdata  = sb_size_ff[TW-1:0] | TW'(sb_used_ff);
      mem_raddr  = '0;
      chunk      = W'(chunk_bytes & ~bta_pkg::CHUNK_W'(7));
      psz        = W'({prev_ff[TW-1:1], 1'b0});
      nsz        = rd_size;
      msize      = sz_ff + (rd_data[0] ? '0 : nsz) + (prev_ff[0] ? '0 : psz);
      mp         = p_ff - (prev_ff[0] ? '0 : psz);
      unique case (state_ff)
         CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = '0;
            cnt_in    = cnt_ff + W'(4);
            if (cnt_ff == W'((TAG_WORDS - 1) * 4)) begin
               state_in = INIT;
            end
         end
         INIT: begin
            mem_we  = 1'b1;
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mem_waddr = W'(4);
                  mem_wdata = TW'(9);
               end
               3'd1: begin
                  mem_waddr = W'(8);
                  mem_wdata = TW'(9);
               end
               3'd2: begin
                  mem_waddr = W'(12);
                  mem_wdata = TW'(bta_pkg::INIT_CHUNK);
               end
               3'd3: begin
                  mem_waddr = W'(bta_pkg::INIT_CHUNK + 8);
                  mem_wdata = TW'(bta_pkg::INIT_CHUNK);
               end
               default: begin
                  mem_waddr = W'(bta_pkg::INIT_CHUNK + 12);
                  mem_wdata = TW'(1);
                  state_in  = IDLE;
               end
            endcase
         end
         IDLE: begin
            if (req_valid) begin
               op_free_in = req_type == bta_pkg::REQ_FREE;
               off_in     = req_free_offset;
               asize_in   = W'(8) + (W'({1'b0, req_request_bytes} + 17'd7) & ~W'(7));
               h_in       = W'(4);
               best_in    = '0;
               best_sz_in = '0;
               res_off_in = '0;
               res_st_in  = bta_pkg::ST_OK;
               state_in   = WALK_RD;
               if (req_type == bta_pkg::REQ_FREE) begin
                  if (req_free_offset == bta_pkg::OFFSET_W'(8)) begin
                     state_in = DONE;
                  end
               end else if (req_request_bytes == '0) begin
                  res_st_in = bta_pkg::ST_ZERO;
                  state_in  = DONE;
               end
            end
         end
         WALK_RD: begin
            mem_raddr = h_ff;
            state_in  = WALK_CHK;
         end
         WALK_CHK: begin
            if (rd_size == '0 || h_ff >= brk_ff) begin
               if (op_free_ff) begin
                  state_in = DONE;
               end else if (best_ff != '0) begin
                  p_in     = best_ff;
                  state_in = PLC_RD;
               end else begin
                  state_in = ALLOC_END;
               end
            end else if (op_free_ff) begin
               h_in     = h_ff + rd_size;
               state_in = WALK_RD;
               if (h_ff + W'(4) == W'(off_ff)) begin
                  if (rd_data[0]) begin
                     sb_p_in    = W'(off_ff);
                     sb_size_in = rd_size;
                     sb_used_in = 1'b0;
                     sb_ret_in  = MRG_A;
                     p_in       = W'(off_ff);
                     guard_in   = '0;
                     state_in   = SB_HDR;
                  end else begin
                     state_in = DONE;
                  end
               end
            end else begin
               if (!rd_data[0] && rd_size >= asize_ff &&
                   (best_ff == '0 || rd_size < best_sz_ff)) begin
                  best_in    = h_ff + W'(4);
                  best_sz_in = rd_size;
               end
               h_in     = h_ff + rd_size;
               state_in = WALK_RD;
            end
         end
         ALLOC_END: begin
            if (chunk == '0) begin
               chunk = W'(8);
            end
            ext_in   = (asize_ff > chunk) ? asize_ff : chunk;
            state_in = EXT_RD;
         end
         EXT_RD: begin
            mem_raddr = epi_ff - W'(4);
            state_in  = EXT_CHK;
         end
         EXT_CHK: begin
            if (!rd_data[0] && rd_size < ext_ff) begin
               ext_in = ext_ff - rd_size;
            end
            state_in = EXT_TST;
         end
         EXT_TST: begin
            if (brk_ff > W'(HEAP_BYTES) || ext_ff > W'(HEAP_BYTES) - brk_ff) begin
               res_st_in = bta_pkg::ST_EXHAUSTED;
               state_in  = DONE;
            end else begin
               sb_p_in    = brk_ff;
               sb_size_in = ext_ff;
               sb_used_in = 1'b0;
               sb_ret_in  = EXT_EPI;
               p_in       = brk_ff;
               state_in   = SB_HDR;
            end
         end
         EXT_EPI: begin
            mem_we    = 1'b1;
            mem_waddr = brk_ff + ext_ff - W'(4);
            mem_wdata = TW'(1);
            brk_in    = brk_ff + ext_ff;
            epi_in    = brk_ff + ext_ff - W'(4);
            guard_in  = '0;
            state_in  = MRG_A;
         end
         MRG_A: begin
            mem_raddr = p_ff - W'(4);
            state_in  = MRG_B;
         end
         MRG_B: begin
            sz_in     = rd_size;
            mem_raddr = p_ff - W'(8);
            state_in  = MRG_C;
         end
         MRG_C: begin
            prev_in   = rd_data;
            mem_raddr = p_ff - W'(4) + sz_ff;
            state_in  = MRG_D;
         end
         MRG_D: begin
            if (prev_ff[0] && rd_data[0]) begin
               state_in = op_free_ff ? DONE : PLC_RD;
            end else begin
               sb_p_in    = mp;
               sb_size_in = msize;
               sb_used_in = 1'b0;
               p_in       = mp;
               guard_in   = guard_ff + 2'd1;
               if (guard_ff == 2'd3) begin
                  sb_ret_in = op_free_ff ? DONE : PLC_RD;
               end else begin
                  sb_ret_in = MRG_A;
               end
               state_in = SB_HDR;
            end
         end
         PLC_RD: begin
            mem_raddr = p_ff - W'(4);
            state_in  = PLC_CHK;
         end
         PLC_CHK: begin
            if (rd_size < asize_ff) begin
               res_st_in = bta_pkg::ST_EXHAUSTED;
               state_in  = DONE;
            end else begin
               res_off_in = p_ff[bta_pkg::OFFSET_W-1:0];
               sb_p_in    = p_ff;
               sb_used_in = 1'b1;
               sz_in      = rd_size;
               state_in   = SB_HDR;
               if (rd_size - asize_ff >= W'(16)) begin
                  sb_size_in = asize_ff;
                  sb_ret_in  = PLC_SPLIT;
               end else begin
                  sb_size_in = rd_size;
                  sb_ret_in  = DONE;
               end
            end
         end
         PLC_SPLIT: begin
            sb_p_in    = p_ff + asize_ff;
            sb_size_in = sz_ff - asize_ff;
            sb_used_in = 1'b0;
            sb_ret_in  = DONE;
            state_in   = SB_HDR;
         end
         SB_HDR: begin
            mem_we   = 1'b1;
            state_in = SB_FTR;
         end
         SB_FTR: begin
            mem_we    = 1'b1;
            mem_waddr = sb_p_ff - W'(8) + sb_size_ff;
            state_in  = sb_ret_ff;
         end
         DONE: begin
            if (out_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         cnt_ff   <= '0;
         step_ff  <= '0;
         brk_ff   <= W'(bta_pkg::INIT_CHUNK + 16);
         epi_ff   <= W'(bta_pkg::INIT_CHUNK + 12);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         brk_ff   <= brk_in;
         epi_ff   <= epi_in;
      end
      sb_ret_ff  <= sb_ret_in;
      op_free_ff <= op_free_in;
      off_ff     <= off_in;
      asize_ff   <= asize_in;
      h_ff       <= h_in;
      best_ff    <= best_in;
      best_sz_ff <= best_sz_in;
      p_ff       <= p_in;
      sz_ff      <= sz_in;
      ext_ff     <= ext_in;
      prev_ff    <= prev_in;
      guard_ff   <= guard_in;
      sb_p_ff    <= sb_p_in;
      sb_size_ff <= sb_size_in;
      sb_used_ff <= sb_used_in;
      res_off_ff <= res_off_in;
      res_st_ff  <= res_st_in;
   end

   a_brk_bound: assert property (@(posedge clock) disable iff (reset)
      brk_ff <= W'(HEAP_BYTES)) else $error("break beyond heap");

   a_epi_brk: assert property (@(posedge clock) disable iff (reset)
      epi_ff + W'(4) == brk_ff) else $error("epilogue not below break");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && req_valid) |=> req_stall) else $error("accepted request not held");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (done_valid && res_st_ff != bta_pkg::ST_OK) |-> res_off_ff == '0)
      else $error("failed request carries an offset");

endmodule
